// ----- hdl/mp3s_pkg.sv -----
// ----------------------------------------------------------------------------
// mp3s_pkg
// Shared types, constants and helpers of the 3x3 stride-2 max pooling stream.
// ----------------------------------------------------------------------------
package mp3s_pkg;

  // Sample and position widths.
  localparam int DATA_WIDTH   = 16;
  localparam int MAX_WIDTH    = 64;
  localparam int COL_W        = 6;
  localparam int ROW_W        = 6;
  localparam int CHAN_W       = 8;
  localparam int SIZE_W       = 7;
  localparam int COUNT_W      = 9;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 9;

  // Legal register ranges.
  localparam logic [SIZE_W-1:0]  SIZE_MIN  = 7'd3;
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MIN = 9'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd256;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  typedef logic signed [DATA_WIDTH-1:0] sample_t;
  typedef logic [COL_W-1:0]             col_t;

  // One line store entry: the same column of the two previous rows.
  typedef struct packed {
    sample_t older;
    sample_t newer;
  } row_pair_t;

  // Signed maximum of two samples.
  function automatic sample_t max_sample(input sample_t a, input sample_t b);
    return ($signed(b) > $signed(a)) ? b : a;
  endfunction

endpackage

// ----- hdl/maxpool_3x3_stride2_stream.sv -----
// ----------------------------------------------------------------------------
// maxpool_3x3_stride2_stream
// 3x3 max pooling with stride 2 and no padding over a stream of samples.
// ----------------------------------------------------------------------------
// The block takes one sample per clock in raster order, channel after channel,
// and gives a pooled beat for every sample that completes a window (even row
// and even column, both at least two). The line store is read and the sample
// is registered in the compute stage as it is taken; the window maximum
// is then registered at the output as the compute stage moves on. The sample
// side stalls only while a pooled beat is held back by a stalled result side.
// The line store is a single 64-entry memory holding both previous rows per
// column, read when a sample is taken and written when it moves on; two column
// cells hold the vertical maxima of the previous columns. A configuration
// write is to be made while no beat is in flight; a write to a known register
// restarts the frame. frame_done marks the last pooled beat of the last channel.
// ----------------------------------------------------------------------------
module maxpool_3x3_stride2_stream (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration port
  input  logic                                 cfg_we,
  input  logic [mp3s_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mp3s_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Sample channel
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  mp3s_pkg::sample_t                    sample,
  // Result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output mp3s_pkg::sample_t                    pooled,
  output logic                                 frame_done
);
  import mp3s_pkg::*;

  // Configuration registers
  logic [SIZE_W-1:0]  plane_height;
  logic [SIZE_W-1:0]  plane_width;
  logic [COUNT_W-1:0] channel_count;

  // Positions in the frame
  logic [ROW_W-1:0]   row_pos;
  logic [COL_W-1:0]   col_pos;
  logic [CHAN_W-1:0]  chan_pos;

  // Compute stage
  logic               b_valid;
  sample_t            b_sample;
  col_t               b_col;
  logic               b_emit;
  logic               b_done;

  logic               in_accept;
  logic               out_free;
  logic               b_go;
  logic               col_last;
  logic               row_last;
  logic               chan_last;
  logic               emit;
  logic               done;
  logic [SIZE_W-1:0]  anchor_h;
  logic [SIZE_W-1:0]  anchor_w;
  logic [SIZE_W-1:0]  cfg_size;
  logic [COUNT_W-1:0] cfg_count;

  row_pair_t          rd_pair;
  row_pair_t          wr_pair;
  sample_t            vert;
  sample_t            cm_newer;
  sample_t            cm_older;
  sample_t            part_mid;
  sample_t            window;

  // Handshake: the compute stage moves on when its beat has somewhere to go.
  assign in_accept    = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;
  assign b_go         = b_valid && (!b_emit || out_free);
  assign sample_stall = b_valid && !b_go;

  // Clamp of written sizes to their legal ranges.
  always_comb begin
    cfg_size = cfg_data[SIZE_W-1:0];
    if (cfg_size < SIZE_MIN) begin
      cfg_size = SIZE_MIN;
    end else if (cfg_size > SIZE_MAX) begin
      cfg_size = SIZE_MAX;
    end
    cfg_count = cfg_data;
    if (cfg_count < COUNT_MIN) begin
      cfg_count = COUNT_MIN;
    end else if (cfg_count > COUNT_MAX) begin
      cfg_count = COUNT_MAX;
    end
  end

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_height  <= SIZE_MIN;
      plane_width   <= SIZE_MIN;
      channel_count <= COUNT_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLANE_HEIGHT:  plane_height  <= cfg_size;
        REG_PLANE_WIDTH:   plane_width   <= cfg_size;
        REG_CHANNEL_COUNT: channel_count <= cfg_count;
        default: ;
      endcase
    end
  end

  // Last anchor of a plane dimension: the largest even index that ends a window.
  assign anchor_h = (plane_height - SIZE_W'(1)) & ~SIZE_W'(1);
  assign anchor_w = (plane_width  - SIZE_W'(1)) & ~SIZE_W'(1);

  assign col_last  = ({1'b0, col_pos} + SIZE_W'(1)) >= plane_width;
  assign row_last  = ({1'b0, row_pos} + SIZE_W'(1)) >= plane_height;
  assign chan_last = ({1'b0, chan_pos} + COUNT_W'(1)) >= channel_count;

  assign emit = (row_pos >= ROW_W'(2)) && !row_pos[0] &&
                (col_pos >= COL_W'(2)) && !col_pos[0];
  assign done = (({1'b0, chan_pos} + COUNT_W'(1)) == channel_count) &&
                ({1'b0, row_pos} == anchor_h) && ({1'b0, col_pos} == anchor_w);

  // Position counters; a write to a known register restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos  <= '0;
      col_pos  <= '0;
      chan_pos <= '0;
    end else if (cfg_we && (cfg_index == REG_PLANE_HEIGHT ||
                            cfg_index == REG_PLANE_WIDTH ||
                            cfg_index == REG_CHANNEL_COUNT)) begin
      row_pos  <= '0;
      col_pos  <= '0;
      chan_pos <= '0;
    end else if (in_accept) begin
      if (col_last) begin
        col_pos <= '0;
        if (row_last) begin
          row_pos  <= '0;
          chan_pos <= chan_last ? '0 : chan_pos + CHAN_W'(1);
        end else begin
          row_pos <= row_pos + ROW_W'(1);
        end
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  // Compute stage valid and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_accept) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_sample <= sample;
      b_col    <= col_pos;
      b_emit   <= emit;
      b_done   <= done;
    end
  end

  // Line store: read as the sample is taken, write back as it moves on.
  assign wr_pair.older = rd_pair.newer;
  assign wr_pair.newer = b_sample;

  mp3s_line_store u_line_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_pos),
    .rd_data (rd_pair),
    .wr_en   (b_go),
    .wr_addr (b_col),
    .wr_data (wr_pair)
  );

  // Vertical maximum of the current column.
  assign vert = max_sample(max_sample(rd_pair.older, rd_pair.newer), b_sample);

  // Column cells: the previous column, then the one before it.
  mp3s_cell u_cell_newer (
    .clk      (clk),
    .shift    (b_go),
    .data_in  (vert),
    .data_out (cm_newer),
    .part_in  (vert),
    .part_out (part_mid)
  );

  mp3s_cell u_cell_older (
    .clk      (clk),
    .shift    (b_go),
    .data_in  (cm_newer),
    .data_out (cm_older),
    .part_in  (part_mid),
    .part_out (window)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_go && b_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_emit) begin
      pooled     <= window;
      frame_done <= b_done;
    end
  end

endmodule

// ----- hdl/mp3s_line_store.sv -----
// ----------------------------------------------------------------------------
// mp3s_line_store
// Line store of the two previous rows, one entry per column, registered read.
// ----------------------------------------------------------------------------
module mp3s_line_store (
  input  logic                 clk,
  input  logic                 rd_en,
  input  mp3s_pkg::col_t       rd_addr,
  output mp3s_pkg::row_pair_t  rd_data,
  input  logic                 wr_en,
  input  mp3s_pkg::col_t       wr_addr,
  input  mp3s_pkg::row_pair_t  wr_data
);
  import mp3s_pkg::*;

  row_pair_t mem [MAX_WIDTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/mp3s_cell.sv -----
// ----------------------------------------------------------------------------
// mp3s_cell
// One column cell: holds the vertical maximum of an earlier column, passes it
// to its neighbour on each beat and folds it into the running window maximum.
// ----------------------------------------------------------------------------
module mp3s_cell (
  input  logic              clk,
  input  logic              shift,
  input  mp3s_pkg::sample_t data_in,
  output mp3s_pkg::sample_t data_out,
  input  mp3s_pkg::sample_t part_in,
  output mp3s_pkg::sample_t part_out
);
  import mp3s_pkg::*;

  sample_t held;

  // Take the column maximum from the left neighbour.
  always_ff @(posedge clk) begin
    if (shift) begin
      held <= data_in;
    end
  end

  assign data_out = held;

  // Running maximum along the chain.
  assign part_out = max_sample(part_in, held);

endmodule

// ----- test/tb_maxpool_3x3_stride2_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_maxpool_3x3_stride2_stream
// Self-checking bench for the 3x3 stride-2 max pooling stream.
// ----------------------------------------------------------------------------
// A behavioural model of the pooling window runs beside the block. It sees
// every accepted sample beat and every register write, and queues the pooled
// beats it expects. Each pooled beat from the block is compared with the
// oldest queued one. A short directed opening covers the sample extremes, an
// even plane width and a restart mid-frame. Random phases then vary plane
// size and channel count, with clamped and ignored writes, while both sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_maxpool_3x3_stride2_stream;
  import mp3s_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned STIM_ITEMS    = 800;
  localparam int unsigned PHASE_CAP     = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    sample_t value;
    logic    last;
  } pooled_beat_t;

  // Window model: line stores, column maxima, positions and settings.
  class pool_scoreboard;
    sample_t      older_row [MAX_WIDTH];
    sample_t      newer_row [MAX_WIDTH];
    sample_t      colmax_far;
    sample_t      colmax_near;
    int unsigned  row_pos, col_pos, chan_pos;
    int unsigned  height, width, channels;
    pooled_beat_t pooled_due [$];
    int unsigned  errors, beats_checked, frames_closed;

    function new();
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      colmax_far    = '0;
      colmax_near   = '0;
      row_pos       = 0;
      col_pos       = 0;
      chan_pos      = 0;
      height        = 3;
      width         = 3;
      channels      = 1;
      errors        = 0;
      beats_checked = 0;
      frames_closed = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function sample_t larger(sample_t a, sample_t b);
      return (b > a) ? b : a;
    endfunction

    // Index of the last row or column at which a window completes.
    function int unsigned last_anchor(int unsigned size);
      return ((size - 3) / 2) * 2 + 2;
    endfunction

    // A write to a known register clamps its value and restarts the frame.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PLANE_HEIGHT:  height   = clamp(data[SIZE_W-1:0], SIZE_MIN, SIZE_MAX);
        REG_PLANE_WIDTH:   width    = clamp(data[SIZE_W-1:0], SIZE_MIN, SIZE_MAX);
        REG_CHANNEL_COUNT: channels = clamp(data, COUNT_MIN, COUNT_MAX);
        default:           return;
      endcase
      row_pos  = 0;
      col_pos  = 0;
      chan_pos = 0;
    endfunction

    // Advance the window by one sample and queue a pooled beat if one is due.
    function void take_sample(sample_t s);
      sample_t      vert;
      pooled_beat_t beat;
      vert = larger(larger(older_row[col_pos], newer_row[col_pos]), s);
      beat.value = larger(larger(colmax_far, colmax_near), vert);
      older_row[col_pos] = newer_row[col_pos];
      newer_row[col_pos] = s;
      colmax_far  = colmax_near;
      colmax_near = vert;

      if (row_pos >= 2 && row_pos % 2 == 0 && col_pos >= 2 && col_pos % 2 == 0) begin
        beat.last = (chan_pos + 1 == channels) && (row_pos == last_anchor(height)) &&
                    (col_pos == last_anchor(width));
        pooled_due.push_back(beat);
      end

      // Raster order within a plane, then the next channel, then a new frame.
      if (col_pos + 1 >= width) begin
        col_pos = 0;
        if (row_pos + 1 >= height) begin
          row_pos  = 0;
          chan_pos = (chan_pos + 1 >= channels) ? 0 : chan_pos + 1;
        end else begin
          row_pos = row_pos + 1;
        end
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(sample_t got_value, logic got_last);
      pooled_beat_t want;
      if (pooled_due.size() == 0) begin
        report($sformatf("unexpected pooled beat %0d last=%b", got_value, got_last));
        return;
      end
      want = pooled_due.pop_front();
      beats_checked++;
      if (got_value !== want.value)
        report($sformatf("pooled %0d, model %0d", got_value, want.value));
      if (got_last !== want.last)
        report($sformatf("frame_done %b, model %b", got_last, want.last));
      if (want.last)
        frames_closed++;
    endtask
  endclass

  logic                   clk;
  logic                   rst          = 1'b1;
  logic                   cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  sample_t                sample       = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  sample_t                pooled;
  logic                   frame_done;

  pool_scoreboard         pool_sb;
  bit                     quiet = 1'b1;
  int unsigned            cycle_count = 0;
  int unsigned            samples_sent = 0;
  int unsigned            settings_used = 0;
  int unsigned            out_wait = 0;
  logic [CFG_IDX_W-1:0]   reg_order [3];

  maxpool_3x3_stride2_stream i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pooled       (pooled),
    .frame_done   (frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle cycles before the next beat on either side; none in quiet stretches.
  function automatic int unsigned draw_wait();
    if (quiet || $urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(0, 14);
  endfunction

  // Samples lean towards the extremes so that signed compares are stressed.
  function automatic sample_t draw_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return '1;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Plane sizes are mostly small, with the limits and clamped values mixed in.
  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return CFG_DATA_W'($urandom_range(0, 2));
      1:       return CFG_DATA_W'($urandom_range(65, 511));
      2:       return 9'd64;
      3:       return 9'd3;
      4, 5:    return CFG_DATA_W'($urandom_range(10, 63));
      default: return CFG_DATA_W'($urandom_range(3, 9));
    endcase
  endfunction

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats outstanding.",
               cycle_count, pool_sb.pooled_due.size());
      $display("tb_maxpool_3x3_stride2_stream: done, errors");
      $finish;
    end
  end

  // Result side: check each accepted beat, then hold off for a random spell.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      pool_sb.check_result(pooled, frame_done);
      out_wait = draw_wait();
    end else if (out_wait != 0) begin
      out_wait--;
    end
    result_stall <= (out_wait != 0);
  end

  // Offer one sample beat and hold it until the block takes it.
  task automatic push_sample(sample_t value);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    do @(posedge clk); while (sample_stall);
    pool_sb.take_sample(value);
    samples_sent++;
  endtask

  // Stop sending and wait for every pooled beat, then for the pipeline to empty.
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pool_sb.pooled_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The write enable is left high so back-to-back writes need no second drive.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    pool_sb.write_reg(idx, data);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] raw [3];
    int unsigned           first, plane, frame_len, n;

    pool_sb      = new();
    reg_order[0] = REG_PLANE_HEIGHT;
    reg_order[1] = REG_PLANE_WIDTH;
    reg_order[2] = REG_CHANNEL_COUNT;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the top-left corner holds the maximum of the window.
    for (int i = 0; i < 9; i++)
      push_sample((i == 0) ? 16'sh7fff : ((i == 8) ? -16'sd1 : 16'sh8000));
    drain_results();

    // A height below range clamps to three; the fourth column of the even width is dropped.
    quiet = 1'b0;
    write_reg(REG_PLANE_HEIGHT, 9'd0);
    write_reg(REG_PLANE_WIDTH, 9'd4);
    write_reg(REG_CHANNEL_COUNT, 9'd1);
    cfg_we <= 1'b0;
    for (int i = 0; i < 12; i++)
      push_sample((i % 4 == 3) ? 16'sh7fff : 16'sh8000);

    // Leave a frame half begun so that the next write has to restart it.
    push_sample(draw_sample());
    push_sample(draw_sample());
    drain_results();
    settings_used = 2;

    // Random phases, each with its own settings and idling pattern.
    while (samples_sent < STIM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        // An unmapped register: nothing changes and the frame carries on.
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 511)));
        cfg_we <= 1'b0;
        n = $urandom_range(20, 100);
      end else begin
        raw[0] = pick_size();
        raw[1] = pick_size();
        case ($urandom_range(0, 9))
          0:       raw[2] = 9'd0;
          1:       raw[2] = CFG_DATA_W'($urandom_range(257, 511));
          2:       raw[2] = 9'd256;
          3, 4:    raw[2] = CFG_DATA_W'($urandom_range(5, 255));
          default: raw[2] = CFG_DATA_W'($urandom_range(1, 4));
        endcase
        first = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
          write_reg(reg_order[(first + k) % 3], raw[(first + k) % 3]);
        cfg_we <= 1'b0;
        settings_used++;

        // Whole frames where they are short, otherwise a slice of one.
        plane     = pool_sb.height * pool_sb.width;
        frame_len = plane * pool_sb.channels;
        if (frame_len <= PHASE_CAP) begin
          n = frame_len;
          if ($urandom_range(0, 2) == 0)
            n += $urandom_range(1, plane);
        end else begin
          n = $urandom_range(50, PHASE_CAP);
        end
        if (n > PHASE_CAP)
          n = PHASE_CAP;
      end

      // The last phase is cut short so the run ends at the planned length.
      if (n > STIM_ITEMS - samples_sent)
        n = STIM_ITEMS - samples_sent;

      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && $urandom_range(0, 4) == 0)
          drain_results();
        push_sample(draw_sample());
      end
      drain_results();
    end

    $display("Sent %0d samples under %0d register settings.", samples_sent, settings_used);
    $display("Checked %0d pooled beats, %0d of them closing a frame.",
             pool_sb.beats_checked, pool_sb.frames_closed);
    if (pool_sb.errors == 0) begin
      $display("tb_maxpool_3x3_stride2_stream: done, clean");
    end else begin
      $display("tb_maxpool_3x3_stride2_stream: done, errors");
    end
    $finish;
  end

endmodule
